[hdl/keyed_alphabet_periodic_decrypt_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef KEYED_ALPHABET_PERIODIC_DECRYPT_MACROS_SVH
`define KEYED_ALPHABET_PERIODIC_DECRYPT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KAPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KAPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/kapd_pkg.sv]
// Package: widths, codes, FSM states and controller/datapath command and status types.
package kapd_pkg;

    localparam int LETTER_W         = 5;
    localparam int MODE_W           = 2;
    localparam int LETTER_COUNT_DEF = 26;
    localparam int MAX_CYCLE_DEF    = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_KEY    = 2'd0,
        MODE_CYCLE  = 2'd1,
        MODE_CIPHER = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_KEY,
        ST_POSK,
        ST_SUB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic place_in;
        logic cyc_wr;
        logic ct_latch;
        logic fill_start;
        logic fill_step;
        logic key_rd;
        logic posk_rd;
        logic sub_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic letter_ok;
        logic complete;
        logic len_zero;
        logic fill_last;
        logic out_free;
    } status_t;

endpackage

[hdl/kapd_in_if.sv]
// Input request channel: mode and letter with valid/ready.
interface kapd_in_if;
    logic                          valid;
    logic                          ready;
    logic [kapd_pkg::MODE_W-1:0]   mode;
    logic [kapd_pkg::LETTER_W-1:0] letter;

    modport source (output valid, output mode, output letter, input ready);
    modport sink   (input valid, input mode, input letter, output ready);
endinterface

[hdl/kapd_out_if.sv]
// Result request channel: plaintext letter and status with valid/ready.
interface kapd_out_if;
    logic                          valid;
    logic                          ready;
    logic [kapd_pkg::LETTER_W-1:0] plain_letter;
    logic                          status;

    modport source (output valid, output plain_letter, output status, input ready);
    modport sink   (input valid, input plain_letter, input status, output ready);
endinterface

[hdl/kapd_datapath.sv]
// Datapath: alphabet and cycle stores, position arithmetic, output register.
module kapd_datapath #(
    parameter int LETTER_COUNT = kapd_pkg::LETTER_COUNT_DEF,
    parameter int MAX_CYCLE    = kapd_pkg::MAX_CYCLE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kapd_pkg::LETTER_W-1:0] in_letter,
    input  kapd_pkg::cmd_t                cmd,
    output kapd_pkg::status_t             sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [kapd_pkg::LETTER_W-1:0] out_plain_letter,
    output logic                          out_status
);

    localparam int POS_W  = $clog2(LETTER_COUNT);
    localparam int CNT_W  = $clog2(LETTER_COUNT + 1);
    localparam int CLEN_W = $clog2(MAX_CYCLE + 1);
    localparam int CIDX_W = (MAX_CYCLE > 1) ? $clog2(MAX_CYCLE) : 1;

    logic [LETTER_COUNT-1:0] pos_valid_reg;
    logic [CNT_W-1:0]        placed_count_reg;
    logic                    complete_reg;
    logic [CLEN_W-1:0]       cycle_length_reg;
    logic [CIDX_W-1:0]       cycle_index_reg;
    logic [POS_W-1:0]        walk_reg;
    logic                    out_valid_reg;

    logic [POS_W-1:0]                ct_reg;
    logic [POS_W-1:0]                pc_reg;
    logic [kapd_pkg::LETTER_W-1:0]   out_plain_reg;
    logic                            out_status_reg;

    logic [POS_W-1:0]              pos_mem   [LETTER_COUNT];
    logic [kapd_pkg::LETTER_W-1:0] alpha_mem [LETTER_COUNT];
    logic [POS_W-1:0]              cycle_mem [MAX_CYCLE];
    logic [POS_W-1:0]              pos_rd_reg;
    logic [kapd_pkg::LETTER_W-1:0] alpha_rd_reg;
    logic [POS_W-1:0]              cycle_rd_reg;

    logic              letter_ok;
    logic [POS_W-1:0]  in_idx;
    logic              full;
    logic              cyc_full;
    logic              place_en;
    logic [POS_W-1:0]  place_letter;
    logic [POS_W-1:0]  k_idx;
    logic [POS_W-1:0]  pos_rd_addr;
    logic [POS_W:0]    diff;
    logic [POS_W-1:0]  p_idx;
    logic [CLEN_W-1:0] idx_inc;
    logic              fill_last;

    assign letter_ok = (32'(in_letter) < LETTER_COUNT);
    assign in_idx    = in_letter[POS_W-1:0];
    assign full      = (placed_count_reg == CNT_W'(LETTER_COUNT));
    assign cyc_full  = (cycle_length_reg == CLEN_W'(MAX_CYCLE));
    assign fill_last = (walk_reg == POS_W'(LETTER_COUNT - 1));

    // one placement source at a time: keyword request or completion walk
    always_comb
    begin
        place_letter = walk_reg;
        place_en     = 1'b0;
        if (cmd.place_in)
        begin
            place_letter = in_idx;
            place_en     = !pos_valid_reg[in_idx] && !full;
        end
        else if (cmd.fill_step)
        begin
            place_letter = walk_reg;
            place_en     = !pos_valid_reg[walk_reg] && !full;
        end
    end

    // indicator letter, forced to zero if never a real letter
    assign k_idx       = (32'(cycle_rd_reg) < LETTER_COUNT) ? cycle_rd_reg : '0;
    assign pos_rd_addr = cmd.key_rd ? ct_reg : k_idx;

    // (pc - pk) mod LETTER_COUNT, sum stays below twice the modulus
    assign diff  = {1'b0, pc_reg} + (POS_W + 1)'(LETTER_COUNT) - {1'b0, pos_rd_reg};
    assign p_idx = (32'(diff) >= LETTER_COUNT) ?
                   POS_W'(diff - (POS_W + 1)'(LETTER_COUNT)) : diff[POS_W-1:0];

    assign idx_inc = CLEN_W'(cycle_index_reg) + CLEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg    <= '0;
            placed_count_reg <= '0;
            complete_reg     <= 1'b0;
            cycle_length_reg <= '0;
            cycle_index_reg  <= '0;
            walk_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                pos_valid_reg    <= '0;
                placed_count_reg <= '0;
                complete_reg     <= 1'b0;
                cycle_length_reg <= '0;
                cycle_index_reg  <= '0;
            end
            if (place_en)
            begin
                pos_valid_reg[place_letter] <= 1'b1;
                placed_count_reg            <= placed_count_reg + CNT_W'(1);
            end
            if (cmd.fill_start)
                walk_reg <= '0;
            else if (cmd.fill_step)
            begin
                walk_reg <= walk_reg + POS_W'(1);
                if (fill_last)
                    complete_reg <= 1'b1;
            end
            if (cmd.cyc_wr && !cyc_full)
                cycle_length_reg <= cycle_length_reg + CLEN_W'(1);
            if (cmd.sub_rd)
            begin
                if (idx_inc >= cycle_length_reg)
                    cycle_index_reg <= '0;
                else
                    cycle_index_reg <= idx_inc[CIDX_W-1:0];
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ct_latch)
            ct_reg <= in_idx;
        if (cmd.posk_rd)
            pc_reg <= pos_rd_reg;
        if (cmd.out_load)
        begin
            out_plain_reg  <= (cycle_length_reg == '0) ? '0 : alpha_rd_reg;
            out_status_reg <= (cycle_length_reg == '0);
        end
    end

    // letter -> position store
    always_ff @(posedge clk)
    begin
        if (place_en)
            pos_mem[place_letter] <= placed_count_reg[POS_W-1:0];
        if (cmd.key_rd || cmd.posk_rd)
            pos_rd_reg <= pos_mem[pos_rd_addr];
    end

    // position -> letter store
    always_ff @(posedge clk)
    begin
        if (place_en)
            alpha_mem[placed_count_reg[POS_W-1:0]] <= kapd_pkg::LETTER_W'(place_letter);
        if (cmd.sub_rd)
            alpha_rd_reg <= alpha_mem[p_idx];
    end

    // indicator store
    always_ff @(posedge clk)
    begin
        if (cmd.cyc_wr && !cyc_full)
            cycle_mem[cycle_length_reg[CIDX_W-1:0]] <= in_idx;
        if (cmd.key_rd)
            cycle_rd_reg <= cycle_mem[cycle_index_reg];
    end

    assign sts.letter_ok = letter_ok;
    assign sts.complete  = complete_reg;
    assign sts.len_zero  = (cycle_length_reg == '0);
    assign sts.fill_last = fill_last;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_plain_letter = out_plain_reg;
    assign out_status       = out_status_reg;

endmodule

[hdl/kapd_ctrl.sv]
// Controller: sequences each request through the datapath.
module kapd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [kapd_pkg::MODE_W-1:0] in_mode,
    output logic                        in_ready,
    input  kapd_pkg::status_t           sts,
    output kapd_pkg::cmd_t              cmd
);

    kapd_pkg::state_t state_reg;
    kapd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= kapd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            kapd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (kapd_pkg::mode_t'(in_mode))
                        kapd_pkg::MODE_CLEAR:
                            cmd.clear = 1'b1;
                        kapd_pkg::MODE_KEY:
                            cmd.place_in = sts.letter_ok && !sts.complete;
                        kapd_pkg::MODE_CYCLE:
                            cmd.cyc_wr = sts.letter_ok && !sts.complete;
                        kapd_pkg::MODE_CIPHER:
                        begin
                            if (sts.letter_ok)
                            begin
                                cmd.ct_latch = 1'b1;
                                if (sts.complete)
                                    state_next = kapd_pkg::ST_KEY;
                                else
                                begin
                                    cmd.fill_start = 1'b1;
                                    state_next     = kapd_pkg::ST_FILL;
                                end
                            end
                        end
                        default:
                            cmd = '0;
                    endcase
                end
            end
            kapd_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                    state_next = kapd_pkg::ST_KEY;
            end
            kapd_pkg::ST_KEY:
            begin
                if (sts.len_zero)
                    state_next = kapd_pkg::ST_OUT;
                else
                begin
                    cmd.key_rd = 1'b1;
                    state_next = kapd_pkg::ST_POSK;
                end
            end
            kapd_pkg::ST_POSK:
            begin
                cmd.posk_rd = 1'b1;
                state_next  = kapd_pkg::ST_SUB;
            end
            kapd_pkg::ST_SUB:
            begin
                cmd.sub_rd = 1'b1;
                state_next = kapd_pkg::ST_OUT;
            end
            kapd_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = kapd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = kapd_pkg::ST_IDLE;
        endcase
    end

endmodule

[hdl/keyed_alphabet_periodic_decrypt.sv]
// Keyword, cycleword, clear and out-of-alphabet ciphertext requests finish in the accept
// cycle; a ciphertext letter of the alphabet holds ready low until the controller is idle,
// reading the single-port position store twice in turn (with a cycleword), then the
// alphabet store. The first one after reset or clear also runs the walk that appends
// unplaced letters, one letter per cycle. rst_n is asynchronous, active low, and empties
// alphabet, cycleword and output; store contents are not cleared, valid bits guard them.
module keyed_alphabet_periodic_decrypt #(
    parameter int LETTER_COUNT = kapd_pkg::LETTER_COUNT_DEF,
    parameter int MAX_CYCLE    = kapd_pkg::MAX_CYCLE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    kapd_in_if.sink   item,
    kapd_out_if.source result
);

    // command and status between controller and datapath
    kapd_pkg::cmd_t    cmd;
    kapd_pkg::status_t sts;

    // Controller: idle state takes requests; keyword, cycleword and clear finish in the accept
    // cycle, ciphertext walks FILL (once), KEY, POSK, SUB, OUT (KEY, OUT with no cycleword).
    kapd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: position and alphabet stores, indicator store, mod subtract and the
    // result register, which lets a new request in while a result waits.
    kapd_datapath #(
        .LETTER_COUNT (LETTER_COUNT),
        .MAX_CYCLE    (MAX_CYCLE)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_letter        (item.letter),
        .cmd              (cmd),
        .sts              (sts),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_plain_letter (result.plain_letter),
        .out_status       (result.status)
    );

endmodule

[hdl/kapd_checker.sv]
// Port-level checker for the decryptor, bound to the top level.
`include "keyed_alphabet_periodic_decrypt_macros.svh"

module kapd_checker #(
    parameter int LETTER_COUNT = kapd_pkg::LETTER_COUNT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic [kapd_pkg::MODE_W-1:0]   item_mode,
    input logic [kapd_pkg::LETTER_W-1:0] item_letter,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [kapd_pkg::LETTER_W-1:0] result_plain_letter,
    input logic                          result_status
);

    // stalled result keeps its payload
    `KAPD_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_plain_letter) && $stable(result_status), "result changed while stalled")

    // error result carries letter zero
    `KAPD_ASSERT_IMPLY(a_err_zero, clk, rst_n, result_valid && result_status, result_plain_letter == '0, "error result with nonzero letter")

    // plaintext is always a letter of the alphabet
    `KAPD_ASSERT_IMPLY(a_plain_range, clk, rst_n, result_valid, 32'(result_plain_letter) < LETTER_COUNT, "plaintext letter out of range")

    // an accepted ciphertext letter of the alphabet holds ready low in the next cycle
    `KAPD_ASSERT_NEXT(a_cipher_busy, clk, rst_n, item_valid && item_ready && (item_mode == kapd_pkg::MODE_CIPHER) && (32'(item_letter) < LETTER_COUNT), !item_ready, "ready while ciphertext in work")

endmodule

bind keyed_alphabet_periodic_decrypt kapd_checker #(
    .LETTER_COUNT (LETTER_COUNT)
) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item.valid),
    .item_ready          (item.ready),
    .item_mode           (item.mode),
    .item_letter         (item.letter),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_plain_letter (result.plain_letter),
    .result_status       (result.status)
);

[tb/sv/kapd_decrypt_checker.sv]
`timescale 1ns / 100ps
// Checker: watches both request channels, predicts plaintext and counts mismatches.
module kapd_decrypt_checker
    import kapd_pkg::*;
#(
    parameter int LETTER_COUNT = LETTER_COUNT_DEF,
    parameter int MAX_CYCLE    = MAX_CYCLE_DEF
) (
    input  logic clk,
    input  logic rst_n,
    kapd_in_if   item,
    kapd_out_if  result,
    output int   fail_count,
    output int   outstanding
);

    typedef struct packed {
        logic [LETTER_W-1:0] plain_letter;
        logic                status;
    } plaintext_t;

    plaintext_t plaintext_q[$];

    // Predicted cipher state
    logic                placed    [LETTER_COUNT];
    logic [LETTER_W-1:0] position  [LETTER_COUNT];
    logic [LETTER_W-1:0] alphabet  [LETTER_COUNT];
    logic [LETTER_W-1:0] indicator [MAX_CYCLE];
    int unsigned         placed_count;
    int unsigned         cycle_len;
    int unsigned         cycle_idx;
    logic                complete;
    int                  errors;

    task automatic clear_key_state();
        for (int i = 0; i < LETTER_COUNT; i++) begin
            placed[i]   = 1'b0;
            position[i] = '0;
            alphabet[i] = '0;
        end
        placed_count = 0;
        cycle_len    = 0;
        cycle_idx    = 0;
        complete     = 1'b0;
    endtask

    // First occurrence takes the next slot; repeats drop out.
    task automatic append_letter(input int unsigned l);
        if (!placed[l] && placed_count < LETTER_COUNT) begin
            placed[l]              = 1'b1;
            position[l]            = LETTER_W'(placed_count);
            alphabet[placed_count] = LETTER_W'(l);
            placed_count++;
        end
    endtask

    task automatic decrypt_request(input mode_t m, input logic [LETTER_W-1:0] l);
        int unsigned         shift;
        logic [LETTER_W-1:0] key;
        if (m == MODE_CLEAR) begin
            clear_key_state();
        end
        else if (l < LETTER_COUNT) begin
            case (m)
                MODE_KEY: begin
                    if (!complete)
                        append_letter(l);
                end
                MODE_CYCLE: begin
                    if (!complete && cycle_len < MAX_CYCLE) begin
                        indicator[cycle_len] = l;
                        cycle_len++;
                    end
                end
                MODE_CIPHER: begin
                    if (!complete) begin
                        for (int i = 0; i < LETTER_COUNT; i++)
                            append_letter(i);
                        complete = 1'b1;
                    end
                    if (cycle_len == 0) begin
                        plaintext_q.push_back('{plain_letter: '0, status: 1'b1});
                    end
                    else begin
                        if (cycle_idx >= cycle_len)
                            cycle_idx = 0;
                        key   = indicator[cycle_idx];
                        shift = (position[l] + LETTER_COUNT - position[key]) % LETTER_COUNT;
                        plaintext_q.push_back('{plain_letter: alphabet[shift], status: 1'b0});
                        cycle_idx++;
                        if (cycle_idx >= cycle_len)
                            cycle_idx = 0;
                    end
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        plaintext_t want;
        if (!rst_n) begin
            clear_key_state();
            plaintext_q.delete();
            errors      = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else begin
            if (result.valid && result.ready) begin
                if (plaintext_q.size() == 0) begin
                    $error("unexpected plaintext: plain_letter %0d status %0d",
                           result.plain_letter, result.status);
                    errors++;
                end
                else begin
                    want = plaintext_q.pop_front();
                    if (result.plain_letter !== want.plain_letter) begin
                        $error("plain_letter: expected %0d, actual %0d",
                               want.plain_letter, result.plain_letter);
                        errors++;
                    end
                    if (result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        errors++;
                    end
                end
            end
            if (item.valid && item.ready)
                decrypt_request(mode_t'(item.mode), item.letter);
            fail_count  <= errors;
            outstanding <= plaintext_q.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
module tb_top;
    import kapd_pkg::*;

    localparam int LETTER_COUNT  = LETTER_COUNT_DEF;
    localparam int MAX_CYCLE     = MAX_CYCLE_DEF;
    localparam int ITEM_TARGET   = 550;
    localparam int PHASE_ITEMS   = ITEM_TARGET / 4;
    // Longest quiet stretch after the last result: ciphertext latency plus
    // the alphabet completion walk, with margin.
    localparam int SETTLE_CYCLES = 64;
    // Worst case is far below this: ~600 requests with idling, stalling and the
    // alphabet walk.
    localparam int CYCLE_LIMIT   = 400_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int outstanding;
    int idle_pct    = 0;   // sender: chance in 100 of a gap before a request
    int stall_pct   = 0;   // receiver: chance in 100 of holding ready low
    int sent        = 0;   // requests that are clears or carry an alphabet letter
    int cycle_count = 0;

    kapd_in_if  item_if ();
    kapd_out_if result_if ();

    keyed_alphabet_periodic_decrypt #(
        .LETTER_COUNT (LETTER_COUNT),
        .MAX_CYCLE    (MAX_CYCLE)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    kapd_decrypt_checker #(
        .LETTER_COUNT (LETTER_COUNT),
        .MAX_CYCLE    (MAX_CYCLE)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_if),
        .result      (result_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Run guard: a hang anywhere ends up here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result back-pressure, redrawn every cycle from the current stall rate.
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One request. The gap, if any, comes first so valid is only lowered in a
    // step where it is not raised again. Returns at the accepting edge.
    task automatic issue(input mode_t m, input logic [LETTER_W-1:0] l);
        if ($urandom_range(99) < idle_pct) begin
            item_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        item_if.valid  <= 1'b1;
        item_if.mode   <= m;
        item_if.letter <= l;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        if (m == MODE_CLEAR || l < LETTER_COUNT)
            sent++;
    endtask

    // Sender goes quiet until every predicted plaintext letter has come back.
    // The checker's count is registered, hence the first wait.
    task automatic await_plaintext();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly real letters, one in twenty out of the alphabet.
    function automatic logic [LETTER_W-1:0] pick_letter();
        if ($urandom_range(19) == 0)
            return LETTER_W'($urandom_range(31, LETTER_COUNT));
        return LETTER_W'($urandom_range(LETTER_COUNT - 1));
    endfunction

    initial begin : stimulus
        int key_len;
        int cyc_len;
        int ct_len;
        int pick;
        int stride;
        int offset;
        int phase_end;

        item_if.valid  <= 1'b0;
        item_if.mode   <= MODE_KEY;
        item_if.letter <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // No cycleword: status error, but the alphabet still completes.
        issue(MODE_CIPHER, 0);
        // Out-of-alphabet ciphertext: no result, no state change.
        issue(MODE_CIPHER, 31);
        // Key and cycle letters after completion are dropped.
        issue(MODE_KEY, 4);
        issue(MODE_CYCLE, 2);
        issue(MODE_CIPHER, 25);
        issue(MODE_CLEAR, 31);
        // Keyword with a repeat and an out-of-range letter, alphabet extremes.
        issue(MODE_KEY, 25);
        issue(MODE_KEY, 0);
        issue(MODE_KEY, 25);
        issue(MODE_KEY, 30);
        issue(MODE_CYCLE, 25);
        issue(MODE_CYCLE, 0);
        issue(MODE_CYCLE, 26);
        issue(MODE_CIPHER, 0);
        issue(MODE_CIPHER, 25);
        issue(MODE_CIPHER, 12);
        issue(MODE_CIPHER, 27);
        issue(MODE_CIPHER, 25);
        // Single-letter cycleword on the default alphabet.
        issue(MODE_CLEAR, 0);
        issue(MODE_CYCLE, 7);
        issue(MODE_CIPHER, 25);
        issue(MODE_CIPHER, 0);

        // ---- random messages ----
        // Phases: free-running, sender gaps, receiver stalls, both.
        // Every phase change waits for the pipeline to empty first.
        for (int phase = 0; phase < 4; phase++) begin
            if (phase != 0)
                await_plaintext();
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) begin
                // A skipped clear makes a broken message on a finished alphabet.
                if ($urandom_range(9) != 0)
                    issue(MODE_CLEAR, LETTER_W'($urandom_range(31)));

                // Keyword: none, a full permutation, or a short random word.
                pick = $urandom_range(9);
                if (pick == 1) begin
                    stride = 2 * $urandom_range(3) + 1;   // odd and not 13: visits all
                    offset = $urandom_range(LETTER_COUNT - 1);
                    for (int k = 0; k < LETTER_COUNT; k++)
                        issue(MODE_KEY, LETTER_W'((k * stride + offset) % LETTER_COUNT));
                end
                else begin
                    key_len = (pick == 0) ? 0 : $urandom_range(10, 1);
                    repeat (key_len) issue(MODE_KEY, pick_letter());
                end

                // Cycleword: none, around the store limit, or short.
                pick = $urandom_range(15);
                if (pick == 0)
                    cyc_len = 0;
                else if (pick == 1)
                    cyc_len = $urandom_range(MAX_CYCLE + 4, MAX_CYCLE - 2);
                else
                    cyc_len = $urandom_range(7, 1);
                repeat (cyc_len) issue(MODE_CYCLE, pick_letter());

                // Ciphertext with stray late key and cycle letters.
                ct_len = $urandom_range(16, 1);
                repeat (ct_len) begin
                    pick = $urandom_range(19);
                    if (pick == 0)
                        issue(MODE_KEY, pick_letter());
                    else if (pick == 1)
                        issue(MODE_CYCLE, pick_letter());
                    else
                        issue(MODE_CIPHER, pick_letter());
                end
            end
        end

        await_plaintext();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/kapd_pkg.sv
hdl/kapd_in_if.sv
hdl/kapd_out_if.sv
hdl/kapd_datapath.sv
hdl/kapd_ctrl.sv
hdl/keyed_alphabet_periodic_decrypt.sv
hdl/kapd_checker.sv
tb/sv/kapd_decrypt_checker.sv
tb/sv/tb_top.sv
